### rtl/block_cipher_256_choice_rotate_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block cipher core
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CIPHER_256_CHOICE_ROTATE_CORE_ASSERT_SVH
`define BLOCK_CIPHER_256_CHOICE_ROTATE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BCR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// antecedent implies consequent in the next cycle
`define BCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

### rtl/bcr_pkg.sv
// ----------------------------------------------------------------------------
// bcr_pkg
// Types, constants and the round permutation of the 256-bit block cipher.
// ----------------------------------------------------------------------------
package bcr_pkg;

	localparam int ROUNDS_DEF = 16;
	localparam int WORD_W     = 64;
	localparam int HALF_W     = 16;
	localparam int HALF_N     = 16;
	localparam int CFG_IDX_W  = 2;

	typedef logic [WORD_W-1:0]         word_t;
	typedef logic [3:0][WORD_W-1:0]    block_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_ZERO  = 2'd0,
		REG_KEY_ONE   = 2'd1,
		REG_KEY_TWO   = 2'd2,
		REG_KEY_THREE = 2'd3
	} cfg_reg_t;

	// source slot of each destination 16-bit slot; also its rotation
	localparam logic [3:0] SRC_SLOT [HALF_N] = '{
		4'd11, 4'd5, 4'd4, 4'd15, 4'd12, 4'd6, 4'd9, 4'd0,
		4'd13, 4'd3, 4'd14, 4'd8, 4'd1, 4'd10, 4'd2, 4'd7
	};

	function automatic word_t ch(word_t x, word_t y, word_t z);
		return z ^ (x & (y ^ z));
	endfunction

	function automatic block_t permute(block_t s);
		word_t                   a;
		word_t                   b;
		word_t                   c;
		word_t                   d;
		logic [HALF_W-1:0]       h [HALF_N];
		logic [2*HALF_W-1:0]     dbl;
		block_t                  n;
		a = s[0];
		b = s[1];
		c = s[2];
		d = s[3];
		a = a ^ ch(b, c, d);
		b = b ^ ch(c, d, a);
		c = c ^ ch(d, a, b);
		d = d ^ ch(a, b, c);
		for (int i = 0; i < 4; i++) begin
			h[i]      = a[HALF_W*i +: HALF_W];
			h[4 + i]  = b[HALF_W*i +: HALF_W];
			h[8 + i]  = c[HALF_W*i +: HALF_W];
			h[12 + i] = d[HALF_W*i +: HALF_W];
		end
		n = '0;
		for (int i = 0; i < HALF_N; i++) begin
			dbl = {h[SRC_SLOT[i]], h[SRC_SLOT[i]]} << SRC_SLOT[i];
			n[i / 4][HALF_W*(i % 4) +: HALF_W] = dbl[2*HALF_W-1:HALF_W];
		end
		return n;
	endfunction

endpackage

### rtl/bcr_key_regs.sv
// ----------------------------------------------------------------------------
// bcr_key_regs
// Cipher key registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module bcr_key_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  bcr_pkg::cfg_reg_t cfg_index,
	input  bcr_pkg::word_t    cfg_data,
	output bcr_pkg::block_t   key
);
	import bcr_pkg::*;

	block_t key_q;

	assign cfg_ready = 1'b1;
	assign key       = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_ZERO:  key_q[0] <= cfg_data;
				REG_KEY_ONE:   key_q[1] <= cfg_data;
				REG_KEY_TWO:   key_q[2] <= cfg_data;
				REG_KEY_THREE: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### rtl/bcr_round.sv
// ----------------------------------------------------------------------------
// bcr_round
// One pipeline stage: permute block (unless whitening) and key, add key.
// ----------------------------------------------------------------------------
`include "block_cipher_256_choice_rotate_core_assert.svh"

module bcr_round (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            whiten,
	input  logic            up_valid,
	output logic            up_ready,
	input  bcr_pkg::block_t up_state,
	input  bcr_pkg::block_t up_key,
	output logic            dn_valid,
	input  logic            dn_ready,
	output bcr_pkg::block_t dn_state,
	output bcr_pkg::block_t dn_key
);
	import bcr_pkg::*;

	logic   valid_s1;
	block_t state_s1;
	block_t key_s1;
	block_t key_next;
	block_t state_mix;

	assign up_ready  = !valid_s1 || dn_ready;
	assign key_next  = permute(up_key);
	assign state_mix = whiten ? up_state : permute(up_state);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			state_s1 <= state_mix ^ key_next;
			key_s1   <= key_next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_state = state_s1;
	assign dn_key   = key_s1;

	`BCR_ASSERT_NEXT(a_hold_on_stall, valid_s1 && !dn_ready, valid_s1 && $stable(state_s1) && $stable(key_s1))
	`BCR_ASSERT_NEXT(a_take_item, up_valid && up_ready, valid_s1)
	`BCR_ASSERT_NEXT(a_no_invent, !up_valid && dn_ready, !valid_s1)
	`BCR_ASSERT_NOW(a_block_full, valid_s1 && !dn_ready, !up_ready)

endmodule

### rtl/block_cipher_256_choice_rotate_core.sv
// ----------------------------------------------------------------------------
// block_cipher_256_choice_rotate_core
// Pipelined 256-bit block cipher: whitening stage plus one stage per round.
// ----------------------------------------------------------------------------
// Channels: plaintext in (plain_valid/plain_stall, four 64-bit words) and
// ciphertext out (cipher_valid/cipher_stall). A transfer happens on a rising
// edge with valid high and stall low. The key sits in four registers written
// through cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write the key only while no block is in flight.
// A block runs through ROUNDS + 1 register stages to ciphertext valid, the
// first loaded at the plaintext transfer edge itself. Throughput: one block
// per cycle while not stalled; every round and the key whitening have a
// register stage of their own, and the key schedule travels with the data.
// Reset clears the key registers to zero and empties the pipeline.
// When the receiver stalls, the last stage holds its block and the stall
// works back stage by stage; empty stages still fill, so plain_stall rises
// only once every stage holds a block.
// ----------------------------------------------------------------------------
module block_cipher_256_choice_rotate_core #(
	parameter int ROUNDS = bcr_pkg::ROUNDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  bcr_pkg::cfg_reg_t cfg_index,
	input  bcr_pkg::word_t    cfg_data,
	input  logic              plain_valid,
	output logic              plain_stall,
	input  bcr_pkg::word_t    plain_word_zero,
	input  bcr_pkg::word_t    plain_word_one,
	input  bcr_pkg::word_t    plain_word_two,
	input  bcr_pkg::word_t    plain_word_three,
	output logic              cipher_valid,
	input  logic              cipher_stall,
	output bcr_pkg::word_t    cipher_word_zero,
	output bcr_pkg::word_t    cipher_word_one,
	output bcr_pkg::word_t    cipher_word_two,
	output bcr_pkg::word_t    cipher_word_three
);
	import bcr_pkg::*;

	localparam int STAGES = ROUNDS + 1;

	logic   vld   [STAGES+1];
	logic   rdy   [STAGES+1];
	block_t state [STAGES+1];
	block_t key   [STAGES+1];

	bcr_key_regs u_key_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key[0])
	);

	assign vld[0]      = plain_valid;
	assign plain_stall = !rdy[0];
	assign state[0]    = {plain_word_three, plain_word_two, plain_word_one, plain_word_zero};

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		bcr_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.whiten   (g == 0),
			.up_valid (vld[g]),
			.up_ready (rdy[g]),
			.up_state (state[g]),
			.up_key   (key[g]),
			.dn_valid (vld[g+1]),
			.dn_ready (rdy[g+1]),
			.dn_state (state[g+1]),
			.dn_key   (key[g+1])
		);
	end

	assign rdy[STAGES]       = !cipher_stall;
	assign cipher_valid      = vld[STAGES];
	assign cipher_word_zero  = state[STAGES][0];
	assign cipher_word_one   = state[STAGES][1];
	assign cipher_word_two   = state[STAGES][2];
	assign cipher_word_three = state[STAGES][3];

endmodule
